// File: rtl/spd_pkg.sv
package spd_pkg;

    localparam int BYTE_W = 8;
    localparam int SUM_W  = 16;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 9;
    localparam int CODE_W = 2;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hEF;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h01;
    localparam logic [SUM_W-1:0]  BASE_MAX_LEN = 16'd32;
    localparam logic [SUM_W-1:0]  MIN_LEN      = 16'd2;
    localparam logic [LEN_W-1:0]  SUM_BYTES    = 9'd2;
    localparam logic [POS_W-1:0]  LAST_ADDR_POS = 8'd3;
    localparam logic [CODE_W-1:0] CODE_RESET   = 2'd2;

    typedef enum logic [7:0] {
        PH_HUNT1 = 8'b0000_0001,
        PH_HUNT2 = 8'b0000_0010,
        PH_ADDR  = 8'b0000_0100,
        PH_ID    = 8'b0000_1000,
        PH_LENHI = 8'b0001_0000,
        PH_LENLO = 8'b0010_0000,
        PH_DATA  = 8'b0100_0000,
        PH_SUM   = 8'b1000_0000
    } t_phase;

endpackage

// File: rtl/spd_if.sv
interface spd_rx_if import spd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spd_res_if import spd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_index;
    logic [BYTE_W-1:0] packet_id;
    logic              frame_end;
    logic              checksum_ok;
    logic              length_error;

    modport source (output valid, output out_byte, output payload_valid,
                    output payload_index, output packet_id, output frame_end,
                    output checksum_ok, output length_error, input ready);
    modport sink   (input valid, input out_byte, input payload_valid,
                    input payload_index, input packet_id, input frame_end,
                    input checksum_ok, input length_error, output ready);
endinterface

// File: rtl/sensor_packet_deframer.sv
// Input beats wait in the input register, result beats in the result register.
// Throughput: one input beat per cycle while results are taken; the parse step
// is one 16-bit add and compare between the input and result registers.
// Reset (synchronous, active low): hunting for the first header byte, all
// counters and sums zero, maximum length code 2, both registers empty.
module sensor_packet_deframer import spd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CODE_W-1:0] i_cfg_wdata,
    spd_rx_if.sink            i_rx,
    spd_res_if.source         o_res
);

    logic [CODE_W-1:0] r_code;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_id, n_id;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [BYTE_W-1:0] r_sum_hi, n_sum_hi;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_pv, n_pv;
    logic [BYTE_W-1:0] r_idx, n_idx;
    logic [BYTE_W-1:0] r_out_id;
    logic              r_fe, n_fe;
    logic              r_ok, n_ok;
    logic              r_le, n_le;
    logic              n_emit;

    logic              proceed;
    logic [SUM_W-1:0]  full_len;
    logic [SUM_W-1:0]  limit;
    logic [LEN_W-1:0]  pos_next;

    assign proceed     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready  = !r_in_valid || proceed;
    assign full_len    = {r_len_hi, r_in_byte};
    assign limit       = BASE_MAX_LEN << r_code;
    assign pos_next    = {1'b0, r_pos} + LEN_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_id       = r_id;
        n_len_hi   = r_len_hi;
        n_len      = r_len;
        n_sum      = r_sum;
        n_sum_hi   = r_sum_hi;
        n_emit     = 1'b0;
        n_out_byte = '0;
        n_pv       = 1'b0;
        n_idx      = '0;
        n_fe       = 1'b0;
        n_ok       = 1'b0;
        n_le       = 1'b0;
        unique case (r_phase)
            PH_HUNT1: begin
                if (r_in_byte == HDR_FIRST) begin
                    n_phase = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (r_in_byte == HDR_SECOND) begin
                    n_phase = PH_ADDR;
                    n_pos   = '0;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_ADDR: begin
                if (r_pos == LAST_ADDR_POS) begin
                    n_pos   = '0;
                    n_phase = PH_ID;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            PH_ID: begin
                n_id    = r_in_byte;
                n_phase = PH_LENHI;
            end
            PH_LENHI: begin
                n_len_hi = r_in_byte;
                n_phase  = PH_LENLO;
            end
            PH_LENLO: begin
                n_pos = '0;
                if (full_len < MIN_LEN || full_len > limit) begin
                    n_phase = PH_HUNT1;
                    n_emit  = 1'b1;
                    n_le    = 1'b1;
                end else begin
                    n_len   = full_len[LEN_W-1:0];
                    n_sum   = {{(SUM_W-BYTE_W){1'b0}}, r_id} + full_len;
                    n_phase = (full_len == MIN_LEN) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                n_emit     = 1'b1;
                n_out_byte = r_in_byte;
                n_pv       = 1'b1;
                n_idx      = r_pos;
                n_sum      = r_sum + {{(SUM_W-BYTE_W){1'b0}}, r_in_byte};
                if (pos_next >= r_len - SUM_BYTES) begin
                    n_pos   = '0;
                    n_phase = PH_SUM;
                end else begin
                    n_pos = pos_next[POS_W-1:0];
                end
            end
            PH_SUM: begin
                if (r_pos == '0) begin
                    n_sum_hi = r_in_byte;
                    n_pos    = POS_W'(1);
                end else begin
                    n_emit  = 1'b1;
                    n_fe    = 1'b1;
                    n_ok    = ({r_sum_hi, r_in_byte} == r_sum);
                    n_pos   = '0;
                    n_phase = PH_HUNT1;
                end
            end
            default: begin
                n_phase = PH_HUNT1;
                n_pos   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code      <= CODE_RESET;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_HUNT1;
            r_pos       <= '0;
            r_id        <= '0;
            r_len_hi    <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_sum_hi    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_code <= i_cfg_wdata;
            end
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end
            if (proceed) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_id        <= n_id;
                r_len_hi    <= n_len_hi;
                r_len       <= n_len;
                r_sum       <= n_sum;
                r_sum_hi    <= n_sum_hi;
                r_out_valid <= n_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (proceed) begin
            r_out_byte <= n_out_byte;
            r_pv       <= n_pv;
            r_idx      <= n_idx;
            r_out_id   <= n_id;
            r_fe       <= n_fe;
            r_ok       <= n_ok;
            r_le       <= n_le;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.out_byte      = r_out_byte;
    assign o_res.payload_valid = r_pv;
    assign o_res.payload_index = r_idx;
    assign o_res.packet_id     = r_out_id;
    assign o_res.frame_end     = r_fe;
    assign o_res.checksum_ok   = r_ok;
    assign o_res.length_error  = r_le;

endmodule
